@@ rtl/wsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared widths, constants and register indexes of the world-to-screen
// projection pipeline.
// ----------------------------------------------------------------------------
package wsp_pkg;

  // configuration port
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;
  localparam int COEF_W = 32;
  localparam int SIZE_W = 14;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X_FIRST  = 3'd0,
    REG_ROW_X_SECOND = 3'd1,
    REG_ROW_Y_FIRST  = 3'd2,
    REG_ROW_Y_SECOND = 3'd3,
    REG_ROW_W_FIRST  = 3'd4,
    REG_ROW_W_SECOND = 3'd5,
    REG_SCREEN_W     = 3'd6,
    REG_SCREEN_H     = 3'd7
  } cfg_idx_t;

  localparam logic [SIZE_W-1:0] SCREEN_W_RST = 14'd1920;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST = 14'd1080;

  // clip arithmetic: terms clamp at +-2^SAT_EXP
  localparam int SAT_EXP = 60;
  localparam int PROD_W  = SAT_EXP + 2;   // one clamped product, signed
  localparam int ACC_W   = SAT_EXP + 3;   // sum of two clamped values, signed
  localparam int MAG_W   = SAT_EXP + 2;   // magnitude of cx + cw
  localparam int DEN_W   = SAT_EXP + 1;   // positive clip w
  localparam int HALF_W  = MAG_W / 2;
  localparam int PIX_SH  = 7;             // width * 128
  localparam int SCALE_W = SIZE_W + PIX_SH;
  localparam int NUM_W   = MAG_W + SCALE_W;

  localparam logic signed [ACC_W-1:0] SAT_POS = ACC_W'(64'sd1 <<< SAT_EXP);
  localparam logic signed [ACC_W-1:0] SAT_NEG = -SAT_POS;

  // output and latency
  localparam int OUT_W     = 32;
  localparam int FRONT_LAT = 7;
  localparam int DIV_LAT   = OUT_W + 2;

endpackage

@@ rtl/wsp_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsp_div
// Pipelined restoring divider, one quotient bit per stage, with the final
// sign, saturation to 32 bits and visibility masking.
// ----------------------------------------------------------------------------
module wsp_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [wsp_pkg::NUM_W-1:0]       num,
  input  logic [wsp_pkg::DEN_W-1:0]       den,
  input  logic                            neg,
  input  logic                            vis,
  output logic signed [wsp_pkg::OUT_W-1:0] res,
  output logic                            vis_out
);

  localparam int QW = wsp_pkg::OUT_W;
  localparam int DW = wsp_pkg::DEN_W;
  localparam int NW = wsp_pkg::NUM_W;

  logic [DW-1:0] rem  [0:QW];
  logic [DW-1:0] dens [0:QW];
  logic [QW-1:0] lowb [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic          over [0:QW];
  logic          negs [0:QW];
  logic          viss [0:QW];

  // first stage: overflow check, high part seeds the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      over[0] <= DW'(num[NW-1:QW]) >= den;
      rem[0]  <= DW'(num[NW-1:QW]);
      lowb[0] <= num[QW-1:0];
      quo[0]  <= '0;
      dens[0] <= den;
      negs[0] <= neg;
      viss[0] <= vis;
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= QW; j++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem[j-1], lowb[j-1][QW-1]};
      ge    = trial >= {1'b0, dens[j-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]  <= ge ? DW'(trial - {1'b0, dens[j-1]}) : DW'(trial);
        quo[j]  <= {quo[j-1][QW-2:0], ge};
        lowb[j] <= {lowb[j-1][QW-2:0], 1'b0};
        dens[j] <= dens[j-1];
        over[j] <= over[j-1];
        negs[j] <= negs[j-1];
        viss[j] <= viss[j-1];
      end
    end
  end

  // sign, saturation and masking
  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MAX = {1'b1, {(QW-1){1'b0}}};

  logic [QW-1:0] res_next;
  always_comb begin
    if (!viss[QW]) begin
      res_next = '0;
    end else if (!negs[QW]) begin
      res_next = (over[QW] || quo[QW] > POS_MAX) ? POS_MAX : quo[QW];
    end else begin
      res_next = (over[QW] || quo[QW] > NEG_MAX) ? NEG_MAX : -quo[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res     <= res_next;
      vis_out <= viss[QW];
    end
  end

endmodule

@@ rtl/world_to_screen_projection.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Projects world points through three view-projection rows and maps them
// to signed Q24.8 pixel coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   input channel: in_valid / in_stall with world_x, world_y, world_z
//   (signed, FRAC_BITS fraction bits). Output channel: out_valid /
//   out_stall with visible, screen_x, screen_y.
//   Configuration: cfg_write with cfg_index and cfg_data, written while
//   no item is in flight. Rows are two registers each, coefficients packed
//   low half first; screen size registers take the low 14 bits.
//   Pipeline: multiply, clamp, accumulate and scale, then the divider: one
//   check stage, 32 quotient-bit stages, one saturation stage.
//   Throughput: one item per cycle while the output is not stalled;
//   the divider's 32 quotient-bit stages make up most of the depth.
//   Stall: the whole pipeline holds while the output item is stalled;
//   in_stall is raised in the same cycles, nothing is lost or repeated.
//   Reset: empties the pipeline, clears all rows, viewport 1920 x 1080.
// ----------------------------------------------------------------------------
module world_to_screen_projection #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_write,
  input  logic [wsp_pkg::IDX_W-1:0]            cfg_index,
  input  logic [wsp_pkg::CFG_W-1:0]            cfg_data,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_WIDTH-1:0]        world_x,
  input  logic signed [COORD_WIDTH-1:0]        world_y,
  input  logic signed [COORD_WIDTH-1:0]        world_z,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 visible,
  output logic signed [wsp_pkg::OUT_W-1:0]     screen_x,
  output logic signed [wsp_pkg::OUT_W-1:0]     screen_y
);

  localparam int CW    = wsp_pkg::COEF_W;
  localparam int PW    = COORD_WIDTH + CW;
  localparam int EW    = (PW > wsp_pkg::PROD_W) ? PW : wsp_pkg::PROD_W;
  localparam int AW    = wsp_pkg::ACC_W;
  localparam int LAT   = wsp_pkg::FRONT_LAT + wsp_pkg::DIV_LAT;
  localparam int HW    = wsp_pkg::HALF_W;
  localparam int MW    = wsp_pkg::MAG_W;
  localparam int SW    = wsp_pkg::SCALE_W;
  localparam logic signed [AW-1:0] W_THRESH = AW'((64'sd1 <<< FRAC_BITS) / 100);
  localparam logic [EW-1:0] SAT_E = EW'(64'd1 << wsp_pkg::SAT_EXP);

  // configuration registers
  logic [wsp_pkg::CFG_W-1:0]  rows [0:5];
  logic [wsp_pkg::SIZE_W-1:0] scr_w;
  logic [wsp_pkg::SIZE_W-1:0] scr_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) rows[i] <= '0;
      scr_w <= wsp_pkg::SCREEN_W_RST;
      scr_h <= wsp_pkg::SCREEN_H_RST;
    end else if (cfg_write) begin
      unique case (wsp_pkg::cfg_idx_t'(cfg_index))
        wsp_pkg::REG_SCREEN_W: scr_w <= cfg_data[wsp_pkg::SIZE_W-1:0];
        wsp_pkg::REG_SCREEN_H: scr_h <= cfg_data[wsp_pkg::SIZE_W-1:0];
        default:               rows[cfg_index] <= cfg_data;
      endcase
    end
  end

  // coefficient split: c0, c1 in first register, c2, c3 in second
  logic signed [CW-1:0] coef [0:2][0:3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = rows[2*r][CW-1:0];
      coef[r][1] = rows[2*r][2*CW-1:CW];
      coef[r][2] = rows[2*r+1][CW-1:0];
      coef[r][3] = rows[2*r+1][2*CW-1:CW];
    end
  end

  // pipeline control
  logic [LAT-1:0] vld;
  logic           en;

  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // stage 1: nine products
  logic signed [COORD_WIDTH-1:0] crd [0:2];
  logic signed [PW-1:0]          prod [0:2][0:2];
  assign crd[0] = world_x;
  assign crd[1] = world_y;
  assign crd[2] = world_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          prod[r][k] <= PW'(crd[k]) * PW'(coef[r][k]);
    end
  end

  // stage 2: truncate magnitude toward zero and clamp
  logic signed [wsp_pkg::PROD_W-1:0] term [0:2][0:2];
  logic signed [wsp_pkg::PROD_W-1:0] term_next [0:2][0:2];
  always_comb begin
    logic [PW-1:0] pm;
    logic [EW-1:0] sh;
    logic [wsp_pkg::PROD_W-1:0] cm;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        pm = prod[r][k][PW-1] ? PW'(-prod[r][k]) : PW'(prod[r][k]);
        sh = EW'(pm >> FRAC_BITS);
        cm = (sh > SAT_E) ? wsp_pkg::PROD_W'(SAT_E) : wsp_pkg::PROD_W'(sh);
        term_next[r][k] = prod[r][k][PW-1] ? -cm : cm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) term <= term_next;
  end

  function automatic logic signed [AW-1:0] sat_add(logic signed [AW-1:0] a,
                                                   logic signed [AW-1:0] b);
    logic signed [AW-1:0] s;
    s = a + b;
    if (s > wsp_pkg::SAT_POS) return wsp_pkg::SAT_POS;
    if (s < wsp_pkg::SAT_NEG) return wsp_pkg::SAT_NEG;
    return s;
  endfunction

  // stage 3: translation plus first two terms
  logic signed [AW-1:0] acc3 [0:2];
  logic signed [wsp_pkg::PROD_W-1:0] t2 [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        acc3[r] <= sat_add(sat_add(AW'(coef[r][3]), AW'(term[r][0])), AW'(term[r][1]));
        t2[r]   <= term[r][2];
      end
    end
  end

  // stage 4: last term
  logic signed [AW-1:0] clp [0:2];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) clp[r] <= sat_add(acc3[r], AW'(t2[r]));
    end
  end

  // stage 5: w test and numerators
  logic signed [AW-1:0] nx, ny;
  logic [MW-1:0]        mx5, my5;
  logic                 negx5, negy5, vis5;
  logic [wsp_pkg::DEN_W-1:0] den5;
  always_comb begin
    nx = clp[0] + clp[2];
    ny = clp[2] - clp[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis5  <= clp[2] > W_THRESH;
      den5  <= clp[2][wsp_pkg::DEN_W-1:0];
      negx5 <= nx[AW-1];
      negy5 <= ny[AW-1];
      mx5   <= nx[AW-1] ? MW'(-nx) : MW'(nx);
      my5   <= ny[AW-1] ? MW'(-ny) : MW'(ny);
    end
  end

  // stage 6: partial products against the pixel scale
  logic [SW-1:0]    scl_x, scl_y;
  logic [HW+SW-1:0] plx, phx, ply, phy;
  logic             negx6, negy6, vis6;
  logic [wsp_pkg::DEN_W-1:0] den6;
  assign scl_x = {scr_w, {wsp_pkg::PIX_SH{1'b0}}};
  assign scl_y = {scr_h, {wsp_pkg::PIX_SH{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      plx   <= (HW+SW)'(mx5[HW-1:0])  * (HW+SW)'(scl_x);
      phx   <= (HW+SW)'(mx5[MW-1:HW]) * (HW+SW)'(scl_x);
      ply   <= (HW+SW)'(my5[HW-1:0])  * (HW+SW)'(scl_y);
      phy   <= (HW+SW)'(my5[MW-1:HW]) * (HW+SW)'(scl_y);
      negx6 <= negx5;
      negy6 <= negy5;
      vis6  <= vis5;
      den6  <= den5;
    end
  end

  // stage 7: combine partial products
  logic [wsp_pkg::NUM_W-1:0] wx, wy;
  logic                      negx7, negy7, vis7;
  logic [wsp_pkg::DEN_W-1:0] den7;
  always_ff @(posedge clk) begin
    if (en) begin
      wx    <= wsp_pkg::NUM_W'(plx) + (wsp_pkg::NUM_W'(phx) << HW);
      wy    <= wsp_pkg::NUM_W'(ply) + (wsp_pkg::NUM_W'(phy) << HW);
      negx7 <= negx6;
      negy7 <= negy6;
      vis7  <= vis6;
      den7  <= den6;
    end
  end

  // dividers
  logic vis_y_unused;

  wsp_div u_div_x (
    .clk     (clk),
    .en      (en),
    .num     (wx),
    .den     (den7),
    .neg     (negx7),
    .vis     (vis7),
    .res     (screen_x),
    .vis_out (visible)
  );

  wsp_div u_div_y (
    .clk     (clk),
    .en      (en),
    .num     (wy),
    .den     (den7),
    .neg     (negy7),
    .vis     (vis7),
    .res     (screen_y),
    .vis_out (vis_y_unused)
  );

`ifndef SYNTHESIS
  // hidden points carry zero coordinates
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == '0 && screen_y == '0)
    else $error("hidden item with nonzero coordinates");

  // both dividers agree on visibility
  a_vis_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> visible == vis_y_unused)
    else $error("divider visibility mismatch");

  // input held off exactly when the output item waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("stall does not follow output back-pressure");

  // accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> vld[0])
    else $error("accepted item lost at entry");
`endif

endmodule
